// File: rtl/core/rmp_pkg.sv
package rmp_pkg;

   // Base graph multipliers for the buffer length N and the information length K.
   localparam logic [6:0] BG1_N_MULT = 7'd66;
   localparam logic [6:0] BG1_K_MULT = 7'd22;
   localparam logic [6:0] BG2_N_MULT = 7'd50;
   localparam logic [6:0] BG2_K_MULT = 7'd10;

   // Saturation limits of the result fields.
   localparam logic [14:0] BPL_MAX = 15'd32767;
   localparam logic [15:0] E_MAX   = 16'd65535;
   localparam logic [14:0] K0_MAX  = 15'd32767;

   // Step counts of the two restoring dividers.
   localparam int DIV_STEPS = 21;
   localparam int K0_STEPS  = 6;

   // Base graph select codes.
   localparam logic BG_ONE = 1'b0;
   localparam logic BG_TWO = 1'b1;

   typedef struct packed {
      logic [18:0] tbs;
      logic        base_graph;
      logic [8:0]  lifting_size;
      logic [3:0]  mod_order;
      logic [2:0]  layers;
      logic [13:0] info_len_no_filler;
      logic [18:0] total_bits;
      logic [1:0]  rv;
      logic [5:0]  num_blocks;
      logic [5:0]  num_blocks_sched;
   } req_type;

   typedef struct packed {
      logic [14:0] bits_per_block_layers;
      logic [15:0] e_len;
      logic [14:0] start_pos;
      logic [5:0]  num_blocks_out;
      logic [5:0]  num_blocks_sched_out;
      logic [3:0]  mod_order_out;
      logic [2:0]  layers_out;
      logic        bad_config;
   } rsp_type;

   // Redundancy version factor m for each base graph.
   function automatic logic [5:0] rv_factor(input logic bg, input logic [1:0] rv);
      logic [5:0] m;
      m = 6'd0;
      if (bg == BG_ONE) begin
         case (rv)
            2'd0: m = 6'd0;
            2'd1: m = 6'd17;
            2'd2: m = 6'd33;
            2'd3: m = 6'd56;
            default: m = 6'd0;
         endcase
      end else begin
         case (rv)
            2'd0: m = 6'd0;
            2'd1: m = 6'd13;
            2'd2: m = 6'd25;
            2'd3: m = 6'd43;
            default: m = 6'd0;
         endcase
      end
      return m;
   endfunction

endpackage

// File: rtl/core/ldpc_rate_match_params.sv
// Each input passes the in, prep, div, mid, k0, post and rsp registers in order.
// Throughput: one item per cycle unless stalled; depth is set by the 21-step
// restoring divider for floor(3*TBS/(2C)) followed by the 6-step one for k0.
// A stall on the result channel freezes the whole pipeline and holds req_stall.
// Reset (synchronous, active high) clears every stage valid bit.
module ldpc_rate_match_params
   import rmp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      req_type     req;
      logic        bad;
      logic [6:0]  d1;
      logic [20:0] aq1;
      logic [12:0] d2;
      logic [20:0] aq2;
      logic [15:0] n;
      logic [13:0] k;
   } prep_type;

   typedef struct packed {
      req_type     req;
      logic        bad;
      logic [6:0]  d1;
      logic [6:0]  rem1;
      logic [20:0] aq1;
      logic [12:0] d2;
      logic [12:0] rem2;
      logic [20:0] aq2;
      logic [15:0] n;
      logic [13:0] k;
   } div_type;

   typedef struct packed {
      req_type     req;
      logic        bad;
      logic [15:0] n;
      logic [15:0] rem;
      logic [5:0]  aq;
      logic [15:0] ncb;
      logic [21:0] cnt;
      logic [13:0] k;
   } k0div_type;

   typedef struct packed {
      req_type     req;
      logic        bad;
      logic [14:0] k0;
      logic [15:0] ncb;
      logic [13:0] k;
      logic [14:0] bpl;
      logic [15:0] e;
   } post_type;

   logic      adv;

   logic      in_vld_ff;
   req_type   in_ff;
   logic      prep_vld_ff;
   prep_type  prep_ff, prep_in;
   logic      div_vld_ff [DIV_STEPS];
   div_type   div_ff [DIV_STEPS];
   div_type   div_in [DIV_STEPS];
   logic      mid_vld_ff;
   k0div_type mid_ff, mid_in;
   logic      k0_vld_ff [K0_STEPS];
   k0div_type k0_ff [K0_STEPS];
   k0div_type k0_in [K0_STEPS];
   logic      post_vld_ff;
   post_type  post_ff, post_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff, rsp_in;

   // The pipeline moves whenever the output register is free or being drained.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Divisors, dividends and code lengths from the raw parameter word.
   always_comb begin
      logic [6:0] st;
      logic [6:0] nm;
      logic [6:0] km;
      st = 7'(in_ff.layers * in_ff.mod_order);
      nm = (in_ff.base_graph == BG_TWO) ? BG2_N_MULT : BG1_N_MULT;
      km = (in_ff.base_graph == BG_TWO) ? BG2_K_MULT : BG1_K_MULT;
      prep_in.req = in_ff;
      prep_in.bad = (in_ff.num_blocks == 6'd0) || (st == 7'd0) ||
                    (in_ff.lifting_size == 9'd0);
      prep_in.d1  = {in_ff.num_blocks, 1'b0};
      prep_in.aq1 = 21'({in_ff.tbs, 1'b0}) + 21'(in_ff.tbs);
      prep_in.d2  = 13'(st * in_ff.num_blocks);
      prep_in.aq2 = {2'b00, in_ff.total_bits};
      prep_in.n   = 16'(nm * in_ff.lifting_size);
      prep_in.k   = 14'(km * in_ff.lifting_size);
   end

   // One quotient bit of each of the two wide divisions per stage.
   always_comb begin
      div_type    src;
      logic [7:0] t1;
      logic [13:0] t2;
      logic       ge1;
      logic       ge2;
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (j == 0) begin
            src.req  = prep_ff.req;
            src.bad  = prep_ff.bad;
            src.d1   = prep_ff.d1;
            src.rem1 = 7'd0;
            src.aq1  = prep_ff.aq1;
            src.d2   = prep_ff.d2;
            src.rem2 = 13'd0;
            src.aq2  = prep_ff.aq2;
            src.n    = prep_ff.n;
            src.k    = prep_ff.k;
         end else begin
            src = div_ff[j-1];
         end
         t1  = {src.rem1, src.aq1[20]};
         t2  = {src.rem2, src.aq2[20]};
         ge1 = t1 >= {1'b0, src.d1};
         ge2 = t2 >= {1'b0, src.d2};
         div_in[j]      = src;
         div_in[j].rem1 = ge1 ? 7'(t1 - {1'b0, src.d1}) : t1[6:0];
         div_in[j].aq1  = {src.aq1[19:0], ge1};
         div_in[j].rem2 = ge2 ? 13'(t2 - {1'b0, src.d2}) : t2[12:0];
         div_in[j].aq2  = {src.aq2[19:0], ge2};
      end
   end

   // Limited buffer length, the k0 dividend and the per-block bit count.
   always_comb begin
      logic [20:0] nref;
      logic [15:0] ncb;
      logic [21:0] prod;
      nref = div_ff[DIV_STEPS-1].aq1;
      ncb  = ({5'd0, div_ff[DIV_STEPS-1].n} < nref) ? div_ff[DIV_STEPS-1].n : nref[15:0];
      prod = 22'(rv_factor(div_ff[DIV_STEPS-1].req.base_graph,
                           div_ff[DIV_STEPS-1].req.rv) * ncb);
      mid_in.req = div_ff[DIV_STEPS-1].req;
      mid_in.bad = div_ff[DIV_STEPS-1].bad;
      mid_in.n   = div_ff[DIV_STEPS-1].n;
      // The quotient is at most m, so six steps over the low bits suffice.
      mid_in.rem = prod[21:6];
      mid_in.aq  = prod[5:0];
      mid_in.ncb = ncb;
      mid_in.cnt = 22'(div_ff[DIV_STEPS-1].aq2[18:0] * div_ff[DIV_STEPS-1].req.layers);
      mid_in.k   = div_ff[DIV_STEPS-1].k;
   end

   // One quotient bit of floor(m*Ncb/N) per stage.
   always_comb begin
      k0div_type   src;
      logic [16:0] t;
      logic        ge;
      for (int j = 0; j < K0_STEPS; j++) begin
         src = (j == 0) ? mid_ff : k0_ff[j-1];
         t   = {src.rem, src.aq[5]};
         ge  = t >= {1'b0, src.n};
         k0_in[j]     = src;
         k0_in[j].rem = ge ? 16'(t - {1'b0, src.n}) : t[15:0];
         k0_in[j].aq  = {src.aq[4:0], ge};
      end
   end

   // Scale k0 by Zc, form E and saturate the bit counts.
   always_comb begin
      logic [25:0] ev;
      ev = 26'(k0_ff[K0_STEPS-1].cnt * k0_ff[K0_STEPS-1].req.mod_order);
      post_in.req = k0_ff[K0_STEPS-1].req;
      post_in.bad = k0_ff[K0_STEPS-1].bad;
      post_in.k0  = 15'(k0_ff[K0_STEPS-1].aq * k0_ff[K0_STEPS-1].req.lifting_size);
      post_in.ncb = k0_ff[K0_STEPS-1].ncb;
      post_in.k   = k0_ff[K0_STEPS-1].k;
      post_in.bpl = (k0_ff[K0_STEPS-1].cnt > 22'(BPL_MAX)) ? BPL_MAX :
                    k0_ff[K0_STEPS-1].cnt[14:0];
      post_in.e   = (ev > 26'(E_MAX)) ? E_MAX : ev[15:0];
   end

   // Move k0 around the filler region and clamp it.
   always_comb begin
      logic signed [17:0] k0s;
      logic signed [17:0] ncbs;
      logic signed [17:0] f;
      logic signed [17:0] k1;
      logic signed [17:0] k2;
      logic signed [17:0] adj;
      logic signed [17:0] zc2;
      zc2  = $signed({8'd0, post_ff.req.lifting_size, 1'b0});
      k0s  = $signed({3'd0, post_ff.k0});
      ncbs = $signed({2'd0, post_ff.ncb});
      f    = $signed({4'd0, post_ff.k}) - $signed({4'd0, post_ff.req.info_len_no_filler});
      k1   = $signed({4'd0, post_ff.k}) - zc2;
      k2   = $signed({4'd0, post_ff.req.info_len_no_filler}) - zc2;
      if (k0s > k1) begin
         adj = k0s - f;
      end else if (k0s > k2 && ncbs > k2 && ncbs <= k1) begin
         adj = 18'sd0;
      end else if (k0s > k2) begin
         adj = k2;
      end else begin
         adj = k0s;
      end
      rsp_in.num_blocks_out       = post_ff.req.num_blocks;
      rsp_in.num_blocks_sched_out = post_ff.req.num_blocks_sched;
      rsp_in.mod_order_out        = post_ff.req.mod_order;
      rsp_in.layers_out           = post_ff.req.layers;
      rsp_in.bad_config           = post_ff.bad;
      if (post_ff.bad) begin
         rsp_in.bits_per_block_layers = 15'd0;
         rsp_in.e_len                 = 16'd0;
         rsp_in.start_pos             = 15'd0;
      end else begin
         rsp_in.bits_per_block_layers = post_ff.bpl;
         rsp_in.e_len                 = post_ff.e;
         if (adj < 18'sd0) begin
            rsp_in.start_pos = 15'd0;
         end else if (adj > $signed({3'd0, K0_MAX})) begin
            rsp_in.start_pos = K0_MAX;
         end else begin
            rsp_in.start_pos = adj[14:0];
         end
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         prep_vld_ff  <= 1'b0;
         mid_vld_ff   <= 1'b0;
         post_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < DIV_STEPS; j++) begin
            div_vld_ff[j] <= 1'b0;
         end
         for (int j = 0; j < K0_STEPS; j++) begin
            k0_vld_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         in_vld_ff    <= req_valid;
         prep_vld_ff  <= in_vld_ff;
         div_vld_ff[0] <= prep_vld_ff;
         for (int j = 1; j < DIV_STEPS; j++) begin
            div_vld_ff[j] <= div_vld_ff[j-1];
         end
         mid_vld_ff   <= div_vld_ff[DIV_STEPS-1];
         k0_vld_ff[0] <= mid_vld_ff;
         for (int j = 1; j < K0_STEPS; j++) begin
            k0_vld_ff[j] <= k0_vld_ff[j-1];
         end
         post_vld_ff  <= k0_vld_ff[K0_STEPS-1];
         rsp_valid_ff <= post_vld_ff;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff   <= req_data;
         prep_ff <= prep_in;
         for (int j = 0; j < DIV_STEPS; j++) begin
            div_ff[j] <= div_in[j];
         end
         mid_ff <= mid_in;
         for (int j = 0; j < K0_STEPS; j++) begin
            k0_ff[j] <= k0_in[j];
         end
         post_ff <= post_in;
         rsp_ff  <= rsp_in;
      end
   end

   // A bad parameter word carries zero numeric results.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bad_config |->
         rsp_ff.e_len == 16'd0 && rsp_ff.start_pos == 15'd0 &&
         rsp_ff.bits_per_block_layers == 15'd0)
      else $error("bad_config result with nonzero fields");

   // With Qm at least one, E never falls below the per-block count.
   a_e_ge_bpl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.bad_config |->
         rsp_ff.e_len >= {1'b0, rsp_ff.bits_per_block_layers})
      else $error("E below the per-block bit count");

   // The pipeline holds while the output transfer is stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(post_vld_ff) && $stable(mid_vld_ff))
      else $error("pipeline moved during a stall");

endmodule
